// ===== sv/isa_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertable shift array package
// Shared types and constants for the list cells and the top level.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int unsigned Capacity = 16;
  // Position and count fields are wide enough for the largest capacity (256).
  localparam int unsigned PosW     = 9;
  localparam int unsigned WordW    = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_INDEX = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_APPEND = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  // Broadcast from the top level to every cell in the row.
  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] value;
    logic [PosW-1:0]  idx;
    logic [PosW-1:0]  cnt;
  } cell_cmd_t;

endpackage

// ===== sv/isa_cell.sv =====
// ----------------------------------------------------------------------------
// Insertable shift array cell
// Holds one list entry; loads the new word, takes its left or right
// neighbor's entry, or holds, depending on its own position.
// ----------------------------------------------------------------------------
module isa_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                       clk_i,
  input  isa_pkg::cell_cmd_t         cmd_i,
  input  logic [isa_pkg::WordW-1:0]  left_i,
  input  logic [isa_pkg::WordW-1:0]  right_i,
  output logic [isa_pkg::WordW-1:0]  data_o,
  output logic [isa_pkg::WordW-1:0]  tap_o
);

  localparam logic [isa_pkg::PosW-1:0] Pos = isa_pkg::PosW'(POS);

  logic [isa_pkg::WordW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      isa_pkg::OP_APPEND: begin
        if (Pos == cmd_i.cnt) data_d = cmd_i.value;
      end
      isa_pkg::OP_INSERT: begin
        if (Pos == cmd_i.idx) begin
          data_d = cmd_i.value;
        end else if (Pos > cmd_i.idx && Pos <= cmd_i.cnt) begin
          data_d = left_i;
        end
      end
      isa_pkg::OP_DELETE: begin
        if (Pos >= cmd_i.idx) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell drives its entry onto the read tap.
  assign tap_o  = (Pos == cmd_i.idx) ? data_q : '0;

endmodule

// ===== sv/insertable_shift_array.sv =====
// A result is registered and appears in the cycle after its command item is accepted.
// One command item per cycle while the output side takes results; every cell
// shifts, loads or holds in the same clock, and the output register decouples the two sides.
// A stalled result holds the input off only while the output register is full.
// Reset clears the entry count and the output valid; entries are not cleared.
// ----------------------------------------------------------------------------
// Insertable shift array
// Fixed-capacity list of signed words built as a row of shifting cells,
// with append, insert, delete and read commands.
// ----------------------------------------------------------------------------
module insertable_shift_array #(
  parameter int unsigned CAPACITY = isa_pkg::Capacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // command[1:0], value[33:2], index[38:34]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // status[1:0], count[6:2], read_value[38:7]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned WW   = isa_pkg::WordW;

  logic [1:0]      cmd;
  logic [WW-1:0]   value;
  logic [4:0]      index;
  assign cmd   = s_axis_tdata_i[1:0];
  assign value = s_axis_tdata_i[33:2];
  assign index = s_axis_tdata_i[38:34];

  logic [CntW-1:0] cnt_d, cnt_q;
  logic            out_valid_q;
  isa_pkg::status_e status_d, status_q;
  logic [4:0]      count_q;
  logic [WW-1:0]   rd_d, rd_q;

  logic                     accept;
  logic                     full;
  logic [isa_pkg::PosW-1:0] idx_ext, cnt_ext;
  isa_pkg::op_e             op_ok;
  isa_pkg::cell_cmd_t       cell_cmd;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_ext         = isa_pkg::PosW'(index);
  assign cnt_ext         = isa_pkg::PosW'(cnt_q);
  assign full            = (cnt_q == CntW'(CAPACITY));

  // Status check and count update for the command at the input.
  always_comb begin
    status_d = isa_pkg::ST_OK;
    op_ok    = isa_pkg::OP_HOLD;
    cnt_d    = cnt_q;
    case (isa_pkg::cmd_e'(cmd))
      isa_pkg::CMD_APPEND: begin
        if (full) begin
          status_d = isa_pkg::ST_FULL;
        end else begin
          op_ok = isa_pkg::OP_APPEND;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      isa_pkg::CMD_INSERT: begin
        if (idx_ext > cnt_ext) begin
          status_d = isa_pkg::ST_INDEX;
        end else if (full) begin
          status_d = isa_pkg::ST_FULL;
        end else begin
          op_ok = isa_pkg::OP_INSERT;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      isa_pkg::CMD_DELETE: begin
        if (idx_ext >= cnt_ext) begin
          status_d = isa_pkg::ST_INDEX;
        end else begin
          op_ok = isa_pkg::OP_DELETE;
          cnt_d = cnt_q - CntW'(1);
        end
      end
      default: begin
        if (idx_ext >= cnt_ext) status_d = isa_pkg::ST_INDEX;
      end
    endcase
  end

  always_comb begin
    cell_cmd.op    = accept ? op_ok : isa_pkg::OP_HOLD;
    cell_cmd.value = value;
    cell_cmd.idx   = idx_ext;
    cell_cmd.cnt   = cnt_ext;
  end

  // Row of cells.
  logic [WW-1:0] data [CAPACITY];
  logic [WW-1:0] tap  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value;
    end else begin : g_mid_l
      assign left_w = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = data[g];
    end else begin : g_mid_r
      assign right_w = data[g+1];
    end
    isa_cell #(
      .POS (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data[g]),
      .tap_o   (tap[g])
    );
  end

  always_comb begin
    rd_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_d = rd_d | tap[i];
    end
    if (!(isa_pkg::cmd_e'(cmd) == isa_pkg::CMD_READ && status_d == isa_pkg::ST_OK)) begin
      rd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      count_q  <= 5'(cnt_d);
      rd_q     <= rd_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, rd_q, count_q, status_q};

  // The entry count never passes the capacity.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // A successful append or insert raises the count by exactly one.
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_ok == isa_pkg::OP_APPEND || op_ok == isa_pkg::OP_INSERT)
    |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("count did not grow by one");

  // A full status is only reported while the list holds the capacity.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d == isa_pkg::ST_FULL |-> cnt_q == CntW'(CAPACITY))
    else $error("full status with room left");

  // A refused command returns a zero read value.
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != isa_pkg::ST_OK |-> rd_q == '0)
    else $error("nonzero read value on a refused command");

endmodule

// ===== tb/insertable_shift_array_tb.sv =====
// ----------------------------------------------------------------------------
// Insertable shift array testbench
// Drives append, insert, delete and read commands through the item stream,
// with random gaps on both sides. A scoreboard keeps its own copy of the
// list and checks every result in order.
// ----------------------------------------------------------------------------
module insertable_shift_array_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1050;
  localparam int unsigned MaxPrinted = 100;
  localparam logic [31:0] MinWord = 32'h8000_0000;
  localparam logic [31:0] MaxWord = 32'h7FFF_FFFF;

  typedef struct {
    isa_pkg::status_e status;
    logic [4:0]       count;
    logic [31:0]      read_value;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  words [isa_pkg::Capacity];
    int unsigned  used;
    list_result_t awaited [$];
    int unsigned  errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Applies one accepted command to the list copy and queues its result.
    function void note_command(isa_pkg::cmd_e cmd, logic [31:0] value,
                               logic [4:0] index);
      list_result_t r;
      int i;
      r.status = isa_pkg::ST_OK;
      r.read_value = '0;
      case (cmd)
        isa_pkg::CMD_APPEND: begin
          if (used >= isa_pkg::Capacity) begin
            r.status = isa_pkg::ST_FULL;
          end else begin
            words[used] = value;
            used++;
          end
        end
        isa_pkg::CMD_INSERT: begin
          // The index is tested before the capacity.
          if (index > used) begin
            r.status = isa_pkg::ST_INDEX;
          end else if (used >= isa_pkg::Capacity) begin
            r.status = isa_pkg::ST_FULL;
          end else begin
            for (i = used; i > index; i--) words[i] = words[i-1];
            words[index] = value;
            used++;
          end
        end
        isa_pkg::CMD_DELETE: begin
          if (index >= used) begin
            r.status = isa_pkg::ST_INDEX;
          end else begin
            for (i = index; i + 1 < used; i++) words[i] = words[i+1];
            used--;
          end
        end
        default: begin
          if (index >= used) r.status = isa_pkg::ST_INDEX;
          else r.read_value = words[index];
        end
      endcase
      r.count = 5'(used);
      awaited.push_back(r);
    endfunction

    task check_result(logic [39:0] word);
      list_result_t exp;
      if (awaited.size() == 0) begin
        report($sformatf("result %h arrived with no command outstanding", word));
        return;
      end
      exp = awaited.pop_front();
      if (word[1:0] !== exp.status)
        report($sformatf("status %0d, expected %0d", word[1:0], exp.status));
      if (word[6:2] !== exp.count)
        report($sformatf("count %0d, expected %0d", word[6:2], exp.count));
      if (word[38:7] !== exp.read_value)
        report($sformatf("read_value %h, expected %h", word[38:7], exp.read_value));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;   // command[1:0], value[33:2], index[38:34]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // status[1:0], count[6:2], read_value[38:7]

  list_scoreboard sb;
  int unsigned    cycles = 0;
  bit             send_calm = 1'b0;
  bit             take_calm = 1'b0;

  insertable_shift_array i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("insertable_shift_array test failed");
      $finish;
    end
  end

  task send_command(isa_pkg::cmd_e cmd, logic [31:0] value, logic [4:0] index);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, index, value, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(cmd, value, index);
  endtask

  // Holds the sender off until every outstanding result has been checked.
  task wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task run_directed();
    int k;
    send_command(isa_pkg::CMD_DELETE, 32'd0, 5'd0);    // delete on an empty list
    send_command(isa_pkg::CMD_INSERT, 32'd5, 5'd1);    // insert past the end
    send_command(isa_pkg::CMD_INSERT, MinWord, 5'd0);
    send_command(isa_pkg::CMD_APPEND, MaxWord, 5'd16);
    send_command(isa_pkg::CMD_INSERT, 32'hFFFF_FFFF, 5'd2);  // index equal to count appends
    send_command(isa_pkg::CMD_INSERT, 32'd0, 5'd1);
    send_command(isa_pkg::CMD_DELETE, 32'd0, 5'd0);
    send_command(isa_pkg::CMD_DELETE, 32'd0, 5'd2);    // remove the last entry
    for (k = 0; k < 14; k++)
      send_command(isa_pkg::CMD_APPEND, $urandom, 5'($urandom_range(0, 16)));
    send_command(isa_pkg::CMD_APPEND, 32'd1, 5'd0);    // append when full
    send_command(isa_pkg::CMD_INSERT, 32'd2, 5'd16);   // insert at the end when full
    send_command(isa_pkg::CMD_INSERT, 32'd3, 5'd0);    // insert at the front when full
    send_command(isa_pkg::CMD_READ, 32'd0, 5'd15);
    send_command(isa_pkg::CMD_READ, 32'd0, 5'd16);     // read out of range
    send_command(isa_pkg::CMD_DELETE, 32'd0, 5'd15);
  endtask

  // Phases that grow, shrink or churn the list, so that full and empty
  // states are visited many times with valid indexes most of the time.
  task run_random(int unsigned items);
    int unsigned   n;
    int unsigned   mode;
    int unsigned   pick;
    int unsigned   used;
    isa_pkg::cmd_e cmd;
    logic [31:0]   value;
    logic [4:0]    index;
    mode = 0;
    for (n = 0; n < items; n++) begin
      used = sb.used;
      if ($urandom_range(0, 39) == 0) mode = $urandom_range(0, 2);
      if (mode == 0 && used == isa_pkg::Capacity && $urandom_range(0, 7) == 0) mode = 1;
      if (mode == 1 && used == 0 && $urandom_range(0, 3) == 0) mode = 0;
      pick = $urandom_range(0, 99);
      case (mode)
        0: cmd = pick < 45 ? isa_pkg::CMD_APPEND : pick < 85 ? isa_pkg::CMD_INSERT :
                 pick < 95 ? isa_pkg::CMD_READ : isa_pkg::CMD_DELETE;
        1: cmd = pick < 10 ? isa_pkg::CMD_APPEND : pick < 20 ? isa_pkg::CMD_INSERT :
                 pick < 45 ? isa_pkg::CMD_READ : isa_pkg::CMD_DELETE;
        default: cmd = pick < 25 ? isa_pkg::CMD_APPEND : pick < 50 ? isa_pkg::CMD_INSERT :
                       pick < 75 ? isa_pkg::CMD_READ : isa_pkg::CMD_DELETE;
      endcase
      case ($urandom_range(0, 9))
        0: value = MinWord;
        1: value = MaxWord;
        2: value = 32'd0;
        3: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      if (cmd == isa_pkg::CMD_APPEND || $urandom_range(0, 6) == 0)
        index = 5'($urandom_range(0, 16));
      else if (cmd == isa_pkg::CMD_INSERT)
        index = 5'($urandom_range(0, used));
      else if (used > 0)
        index = 5'($urandom_range(0, used - 1));
      else
        index = 5'd0;
      send_command(cmd, value, index);
      if (n % 300 == 299) wait_for_drain();
    end
  endtask

  initial begin
    wait (rst_ni);
    forever begin
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o);
    end
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_for_drain();
    run_random(RandomItems);
    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("insertable_shift_array test passed");
    end else begin
      $display("insertable_shift_array test failed");
    end
    $finish;
  end

endmodule
